>>> design/ton_pkg.sv
package ton_pkg;

  // Field and datapath widths.
  localparam int CoordW   = 16;
  localparam int EdgeW    = 17;
  localparam int ProdW    = 34;
  localparam int CrossW   = 35;
  localparam int DotW     = 51;
  localparam int DotSumW  = 53;
  localparam int MagInW   = 34;
  localparam int MagW     = 31;
  localparam int SqW      = 62;
  localparam int SumW     = 64;
  localparam int RootW    = 32;
  localparam int RemW     = 35;
  localparam int FracBits = 14;
  localparam int QuoW     = 15;
  localparam int DivW     = 47;
  localparam int LeadW    = 6;
  localparam int NormTop  = 30;
  localparam int FrontDepth = 9;

  typedef struct packed {
    logic signed [CoordW-1:0] p0_x;
    logic signed [CoordW-1:0] p0_y;
    logic signed [CoordW-1:0] p0_z;
    logic signed [CoordW-1:0] p1_x;
    logic signed [CoordW-1:0] p1_y;
    logic signed [CoordW-1:0] p1_z;
    logic signed [CoordW-1:0] p2_x;
    logic signed [CoordW-1:0] p2_y;
    logic signed [CoordW-1:0] p2_z;
  } tri_t;

  typedef struct packed {
    logic signed [CoordW-1:0] normal_x;
    logic signed [CoordW-1:0] normal_y;
    logic signed [CoordW-1:0] normal_z;
    logic                     degenerate;
  } normal_t;

  typedef logic [2:0][MagW-1:0] mag3_t;

  // Values that ride alongside the square root and the division.
  typedef struct packed {
    mag3_t      mag;
    logic [2:0] flip;
    logic       degen;
  } side_t;

endpackage

>>> design/ton_front.sv
module ton_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  ton_pkg::tri_t          tri_i,
  output logic                   valid_o,
  output logic [ton_pkg::SumW-1:0] sum_o,
  output ton_pkg::side_t         side_o
);
  import ton_pkg::*;

  logic signed [CoordW-1:0] p0 [3];
  logic signed [CoordW-1:0] p1 [3];
  logic signed [CoordW-1:0] p2 [3];

  logic [FrontDepth-1:0] vld_q;

  logic signed [EdgeW-1:0]  u_q [3];
  logic signed [EdgeW-1:0]  v_q [3];
  logic signed [CoordW-1:0] p0a_q [3];
  logic signed [CoordW-1:0] p0b_q [3];
  logic signed [CoordW-1:0] p0c_q [3];
  logic signed [ProdW-1:0]  m_q [6];
  logic signed [CrossW-1:0] c_q [3];
  logic signed [DotW-1:0]   d_q [3];
  logic [MagInW-1:0]        a4_q [3];
  logic [2:0]               csign_q;
  logic                     deg4_q;

  logic signed [DotSumW-1:0] dsum;
  logic [MagInW-1:0]         mx01;
  logic [MagInW-1:0]         mx;
  logic [MagInW-1:0]         a5_q [3];
  logic [MagInW-1:0]         m5_q;
  logic [2:0]                flip5_q;
  logic                      deg5_q;

  logic [LeadW-1:0]  lead;
  logic [MagInW-1:0] a6_q [3];
  logic [LeadW-1:0]  lead6_q;
  logic [2:0]        flip6_q;
  logic              deg6_q;

  logic [MagInW-1:0] nrm [3];
  mag3_t             a7_q;
  logic [2:0]        flip7_q;
  logic              deg7_q;

  logic [SqW-1:0] sq_q [3];
  mag3_t          a8_q;
  logic [2:0]     flip8_q;
  logic           deg8_q;

  logic [SumW-1:0] sum_q;
  side_t           side9_q;

  assign p0[0] = tri_i.p0_x;
  assign p0[1] = tri_i.p0_y;
  assign p0[2] = tri_i.p0_z;
  assign p1[0] = tri_i.p1_x;
  assign p1[1] = tri_i.p1_y;
  assign p1[2] = tri_i.p1_z;
  assign p2[0] = tri_i.p2_x;
  assign p2[1] = tri_i.p2_y;
  assign p2[2] = tri_i.p2_z;

  // Valid bits travel with the data through the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FrontDepth-2:0], valid_i};
    end
  end

  // Stage one: edges at full precision.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        u_q[j]   <= EdgeW'(p1[j]) - EdgeW'(p0[j]);
        v_q[j]   <= EdgeW'(p2[j]) - EdgeW'(p1[j]);
        p0a_q[j] <= p0[j];
      end
    end
  end

  // Stage two: the six cross product terms.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= ProdW'(u_q[1]) * ProdW'(v_q[2]);
      m_q[1] <= ProdW'(u_q[2]) * ProdW'(v_q[1]);
      m_q[2] <= ProdW'(u_q[2]) * ProdW'(v_q[0]);
      m_q[3] <= ProdW'(u_q[0]) * ProdW'(v_q[2]);
      m_q[4] <= ProdW'(u_q[0]) * ProdW'(v_q[1]);
      m_q[5] <= ProdW'(u_q[1]) * ProdW'(v_q[0]);
      for (int j = 0; j < 3; j++) begin
        p0b_q[j] <= p0a_q[j];
      end
    end
  end

  // Stage three: the cross product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0] <= CrossW'(m_q[0]) - CrossW'(m_q[1]);
      c_q[1] <= CrossW'(m_q[2]) - CrossW'(m_q[3]);
      c_q[2] <= CrossW'(m_q[4]) - CrossW'(m_q[5]);
      for (int j = 0; j < 3; j++) begin
        p0c_q[j] <= p0b_q[j];
      end
    end
  end

  // Stage four: dot product terms, magnitudes and the degenerate test.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        d_q[j]     <= DotW'(p0c_q[j]) * DotW'(c_q[j]);
        a4_q[j]    <= c_q[j][CrossW-1] ? MagInW'(-c_q[j]) : MagInW'(c_q[j]);
        csign_q[j] <= c_q[j][CrossW-1];
      end
      deg4_q <= (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);
    end
  end

  // Stage five: orientation from the dot product sign, and the largest magnitude.
  assign dsum = DotSumW'(d_q[0]) + DotSumW'(d_q[1]) + DotSumW'(d_q[2]);
  assign mx01 = (a4_q[0] > a4_q[1]) ? a4_q[0] : a4_q[1];
  assign mx   = (mx01 > a4_q[2]) ? mx01 : a4_q[2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        a5_q[j] <= a4_q[j];
      end
      m5_q    <= mx;
      flip5_q <= csign_q ^ {3{dsum[DotSumW-1]}};
      deg5_q  <= deg4_q;
    end
  end

  // Stage six: position of the leading one of the largest magnitude.
  always_comb begin
    lead = '0;
    for (int i = 0; i < MagInW; i++) begin
      if (m5_q[i]) begin
        lead = LeadW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        a6_q[j] <= a5_q[j];
      end
      lead6_q <= lead;
      flip6_q <= flip5_q;
      deg6_q  <= deg5_q;
    end
  end

  // Stage seven: one common shift puts the leading one at bit thirty.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (lead6_q >= LeadW'(NormTop)) begin
        nrm[j] = a6_q[j] >> (lead6_q - LeadW'(NormTop));
      end else begin
        nrm[j] = a6_q[j] << (LeadW'(NormTop) - lead6_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        a7_q[j] <= nrm[j][MagW-1:0];
      end
      flip7_q <= flip6_q;
      deg7_q  <= deg6_q;
    end
  end

  // Stage eight: squares.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        sq_q[j] <= SqW'(a7_q[j]) * SqW'(a7_q[j]);
      end
      a8_q    <= a7_q;
      flip8_q <= flip7_q;
      deg8_q  <= deg7_q;
    end
  end

  // Stage nine: sum of squares.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q         <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      side9_q.mag   <= a8_q;
      side9_q.flip  <= flip8_q;
      side9_q.degen <= deg8_q;
    end
  end

  assign valid_o = vld_q[FrontDepth-1];
  assign sum_o   = sum_q;
  assign side_o  = side9_q;

endmodule

>>> design/ton_sqrt.sv
module ton_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [ton_pkg::SumW-1:0]  sum_i,
  input  ton_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [ton_pkg::RootW-1:0] root_o,
  output ton_pkg::side_t            side_o
);
  import ton_pkg::*;

  logic              vld_q  [RootW];
  logic [RemW-1:0]   rem_q  [RootW];
  logic [RootW-1:0]  root_q [RootW];
  logic [SumW-1:0]   sum_q  [RootW];
  side_t             side_q [RootW];

  // One root bit per stage, restoring digit by digit from the top.
  for (genvar g = 0; g < RootW; g++) begin : g_stage
    localparam int Bit = RootW - 1 - g;

    logic             vin;
    logic [RemW-1:0]  rin;
    logic [RootW-1:0] qin;
    logic [SumW-1:0]  sin;
    side_t            din;
    logic [RemW-1:0]  rsh;
    logic [RemW-1:0]  trial;
    logic             ge;

    if (g == 0) begin : g_first
      assign vin = valid_i;
      assign rin = '0;
      assign qin = '0;
      assign sin = sum_i;
      assign din = side_i;
    end else begin : g_next
      assign vin = vld_q[g-1];
      assign rin = rem_q[g-1];
      assign qin = root_q[g-1];
      assign sin = sum_q[g-1];
      assign din = side_q[g-1];
    end

    assign rsh   = {rin[RemW-3:0], sin[2*Bit+1 -: 2]};
    assign trial = {1'b0, qin, 2'b01};
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= ge ? (rsh - trial) : rsh;
        root_q[g] <= {qin[RootW-2:0], ge};
        sum_q[g]  <= sin;
        side_q[g] <= din;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

>>> design/ton_div.sv
module ton_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [ton_pkg::RootW-1:0]      root_i,
  input  ton_pkg::side_t                 side_i,
  output logic                           valid_o,
  output logic [2:0][ton_pkg::QuoW-1:0]  quo_o,
  output logic [2:0]                     flip_o,
  output logic                           degen_o
);
  import ton_pkg::*;

  logic                    vld_q  [QuoW];
  logic [2:0][DivW-1:0]    rem_q  [QuoW];
  logic [2:0][QuoW-1:0]    quo_q  [QuoW];
  logic [RootW-1:0]        len_q  [QuoW];
  logic [2:0]              flip_q [QuoW];
  logic                    deg_q  [QuoW];

  // One quotient bit per stage for all three components at once.
  for (genvar g = 0; g < QuoW; g++) begin : g_stage
    localparam int Sh = QuoW - 1 - g;

    logic                 vin;
    logic [2:0][DivW-1:0] rin;
    logic [2:0][QuoW-1:0] qin;
    logic [RootW-1:0]     lin;
    logic [2:0]           fin;
    logic                 din;
    logic [DivW-1:0]      dv;
    logic [2:0]           ge;

    if (g == 0) begin : g_first
      // Rounded numerator: magnitude scaled by 2^14 plus half the length.
      for (genvar j = 0; j < 3; j++) begin : g_num
        assign rin[j] = DivW'({side_i.mag[j], FracBits'(0)}) + DivW'(root_i >> 1);
      end
      assign vin = valid_i;
      assign qin = '0;
      assign lin = root_i;
      assign fin = side_i.flip;
      assign din = side_i.degen;
    end else begin : g_next
      assign vin = vld_q[g-1];
      assign rin = rem_q[g-1];
      assign qin = quo_q[g-1];
      assign lin = len_q[g-1];
      assign fin = flip_q[g-1];
      assign din = deg_q[g-1];
    end

    assign dv = DivW'(lin) << Sh;
    for (genvar j = 0; j < 3; j++) begin : g_cmp
      assign ge[j] = (rin[j] >= dv);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int j = 0; j < 3; j++) begin
          rem_q[g][j] <= ge[j] ? (rin[j] - dv) : rin[j];
          quo_q[g][j] <= {qin[j][QuoW-2:0], ge[j]};
        end
        len_q[g]  <= lin;
        flip_q[g] <= fin;
        deg_q[g]  <= din;
      end
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign flip_o  = flip_q[QuoW-1];
  assign degen_o = deg_q[QuoW-1];

endmodule

>>> design/triangle_outward_unit_normal.sv
// Channel   Direction  Handshake          Payload
// triangle  in         valid_i / stall_o  tri_i  (ton_pkg::tri_t, nine Q4.12 coordinates)
// normal    out        valid_o / stall_i  norm_o (ton_pkg::normal_t, Q1.14 and flag)
//
// One triangle enters per cycle while stall_o is low. Each passes through
// nine front stages, 32 square root stages, 15 division stages and the output register.
// Reset clears only the valid bits and the output and skid flags; no memories are cleared.
// A stalled output holds; one more result lands in a skid register, and stall_o then
// rises for as long as that skid register is full, freezing the whole pipeline.
module triangle_outward_unit_normal (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  ton_pkg::tri_t    tri_i,
  output logic             valid_o,
  input  logic             stall_i,
  output ton_pkg::normal_t norm_o
);
  import ton_pkg::*;

  logic                 en;
  logic                 f_vld;
  logic [SumW-1:0]      f_sum;
  side_t                f_side;
  logic                 s_vld;
  logic [RootW-1:0]     s_root;
  side_t                s_side;
  logic                 d_vld;
  logic [2:0][QuoW-1:0] d_quo;
  logic [2:0]           d_flip;
  logic                 d_deg;
  normal_t              res;
  logic [CoordW-1:0]    comp [3];

  logic    out_vld_q;
  normal_t out_q;
  logic    skid_vld_q;
  normal_t skid_q;

  // The pipeline moves whenever the skid register is free.
  assign en      = !skid_vld_q;
  assign stall_o = skid_vld_q;

  ton_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .tri_i   (tri_i),
    .valid_o (f_vld),
    .sum_o   (f_sum),
    .side_o  (f_side)
  );

  ton_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .sum_i   (f_sum),
    .side_i  (f_side),
    .valid_o (s_vld),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  ton_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_vld),
    .root_i  (s_root),
    .side_i  (s_side),
    .valid_o (d_vld),
    .quo_o   (d_quo),
    .flip_o  (d_flip),
    .degen_o (d_deg)
  );

  // Apply the sign, and force zero for a degenerate triangle.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (d_deg) begin
        comp[j] = '0;
      end else if (d_flip[j]) begin
        comp[j] = -CoordW'(d_quo[j]);
      end else begin
        comp[j] = CoordW'(d_quo[j]);
      end
    end
    res.normal_x   = comp[0];
    res.normal_y   = comp[1];
    res.normal_z   = comp[2];
    res.degenerate = d_deg;
  end

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || !stall_i) begin
      out_vld_q  <= skid_vld_q || d_vld;
      skid_vld_q <= 1'b0;
    end else if (d_vld && en) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || !stall_i) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (d_vld && en) begin
      skid_q <= res;
    end
  end

  assign valid_o = out_vld_q;
  assign norm_o  = out_q;

  // The skid register only fills behind a waiting result.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full with no result in the output register");

  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && stall_i))
    else $error("skid register filled while the output was free");

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.degenerate |->
      out_q.normal_x == '0 && out_q.normal_y == '0 && out_q.normal_z == '0)
    else $error("degenerate result with a non-zero normal");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.degenerate |->
      out_q.normal_x <= 16'sd16384 && out_q.normal_x >= -16'sd16384 &&
      out_q.normal_y <= 16'sd16384 && out_q.normal_y >= -16'sd16384 &&
      out_q.normal_z <= 16'sd16384 && out_q.normal_z >= -16'sd16384)
    else $error("normal component outside the unit range");

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ton_pkg::*;

  localparam int Latency    = 57;
  localparam int RandomTris = 1530;
  localparam longint CycleLimit = 2000000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    valid_i = 1'b0;
  logic    stall_o;
  tri_t    tri_i = '0;
  logic    valid_o;
  logic    stall_i = 1'b0;
  normal_t norm_o;

  // Idling modes for the sender and the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  normal_t expected_normals[$];
  int unsigned mismatches = 0;
  int unsigned normals_seen = 0;
  int unsigned degenerate_seen = 0;
  int unsigned flipped_seen = 0;
  longint cycles = 0;

  triangle_outward_unit_normal DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .tri_i   (tri_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .norm_o  (norm_o)
  );

  always #1 clk_i = ~clk_i;

  // Exact integer square root, floor.
  function automatic longint unsigned floor_sqrt(input longint unsigned s);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Computes the outward unit normal of one triangle.
  function automatic normal_t outward_normal(input tri_t t, output bit flipped);
    longint p0 [3];
    longint p1 [3];
    longint p2 [3];
    longint ed_u [3];
    longint ed_v [3];
    longint cr [3];
    longint unsigned mag [3];
    longint unsigned peak;
    longint unsigned sumsq;
    longint unsigned len;
    longint unsigned q;
    logic [15:0] comp [3];
    bit neg;
    normal_t n;
    p0 = '{longint'(t.p0_x), longint'(t.p0_y), longint'(t.p0_z)};
    p1 = '{longint'(t.p1_x), longint'(t.p1_y), longint'(t.p1_z)};
    p2 = '{longint'(t.p2_x), longint'(t.p2_y), longint'(t.p2_z)};
    flipped = 1'b0;
    for (int j = 0; j < 3; j++) begin
      ed_u[j] = p1[j] - p0[j];
      ed_v[j] = p2[j] - p1[j];
    end
    cr[0] = ed_u[1] * ed_v[2] - ed_u[2] * ed_v[1];
    cr[1] = ed_u[2] * ed_v[0] - ed_u[0] * ed_v[2];
    cr[2] = ed_u[0] * ed_v[1] - ed_u[1] * ed_v[0];
    n = '0;
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
      n.degenerate = 1'b1;
      return n;
    end
    neg = (p0[0] * cr[0] + p0[1] * cr[1] + p0[2] * cr[2]) < 0;
    flipped = neg;
    peak = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = cr[j] < 0 ? longint'(-cr[j]) : cr[j];
      if (mag[j] > peak) peak = mag[j];
    end
    // Block normalisation so that the largest magnitude sits in [2^30, 2^31).
    while (peak >= (64'd1 << 31)) begin
      for (int j = 0; j < 3; j++) mag[j] >>= 1;
      peak >>= 1;
    end
    while (peak < (64'd1 << 30)) begin
      for (int j = 0; j < 3; j++) mag[j] <<= 1;
      peak <<= 1;
    end
    sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = floor_sqrt(sumsq);
    for (int j = 0; j < 3; j++) begin
      q = ((mag[j] << 14) + (len >> 1)) / len;
      comp[j] = ((cr[j] < 0) != neg) ? 16'(-q) : 16'(q);
    end
    n.normal_x = comp[0];
    n.normal_y = comp[1];
    n.normal_z = comp[2];
    return n;
  endfunction

  // Directed triangles; a known normal is given where it is obvious.
  typedef struct {
    tri_t    t;
    bit      known;
    normal_t n;
  } tri_row_t;

  localparam logic signed [15:0] One = 16'sd4096;
  localparam logic signed [15:0] Mx  = 16'sh7FFF;
  localparam logic signed [15:0] Mn  = 16'sh8000;

  tri_row_t directed_rows [] = '{
    // All-zero triangle is degenerate.
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b1}},
    // Collinear points at the extremes are degenerate.
    '{'{Mn, Mn, Mn, 0, 0, 0, Mx, Mx, Mx}, 1'b0, '0},
    '{'{Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx}, 1'b1, '{0, 0, 0, 1'b1}},
    // Unit triangle in the z = 1 plane, already outward.
    '{'{0, 0, One, One, 0, One, One, One, One}, 1'b1, '{0, 0, 16384, 1'b0}},
    // Same plane, reversed winding: negated to point outward.
    '{'{One, One, One, One, 0, One, 0, 0, One}, 1'b1, '{0, 0, 16384, 1'b0}},
    // Plane through the origin: dot product zero, no negation.
    '{'{0, 0, 0, One, 0, 0, One, One, 0}, 1'b1, '{0, 0, 16384, 1'b0}},
    '{'{0, 0, 0, 0, One, 0, One, One, 0}, 1'b1, '{0, 0, -16384, 1'b0}},
    // Axis-aligned normals along x and y.
    '{'{One, 0, 0, One, One, 0, One, One, One}, 1'b1, '{16384, 0, 0, 1'b0}},
    '{'{0, -One, 0, 0, -One, One, One, -One, One}, 1'b1, '{0, -16384, 0, 1'b0}},
    // Extreme coordinates, largest edges.
    '{'{Mn, Mn, Mn, Mx, Mn, Mn, Mx, Mx, Mn}, 1'b0, '0},
    '{'{Mx, Mn, Mx, Mn, Mx, Mn, Mx, Mx, Mn}, 1'b0, '0},
    '{'{Mn, Mx, Mn, Mx, Mn, Mx, Mn, Mn, Mx}, 1'b0, '0},
    '{'{Mx, Mx, Mn, Mn, Mx, Mx, Mx, Mn, Mx}, 1'b0, '0},
    // Tiniest non-zero cross product, needs the largest left shift.
    '{'{0, 0, 0, 1, 0, 0, 1, 1, 0}, 1'b0, '0},
    '{'{-1, -1, -1, 0, -1, -1, 0, 0, -1}, 1'b0, '0},
    // Diagonal normals.
    '{'{One, 0, 0, 0, One, 0, 0, 0, One}, 1'b0, '0},
    '{'{-One, 0, 0, 0, -One, 0, 0, 0, -One}, 1'b0, '0},
    '{'{16'sh5555, 16'shAAAA, 16'sh1234, 16'shFEDC, 16'sh0F0F, 16'shF0F0,
        16'sh7F00, 16'sh00FF, 16'sh8001}, 1'b0, '0}
  };

  // Drives one triangle and waits for its transfer; valid stays high afterwards
  // so that a following triangle can go back to back.
  task automatic send_triangle(input tri_t t, input bit known, input normal_t n);
    bit fl;
    normal_t predicted;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      tri_i   <= tri_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      @(negedge clk_i);
    end
    predicted = outward_normal(t, fl);
    if (known && predicted !== n) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: %p vs %p", n, predicted);
    end
    valid_i <= 1'b1;
    tri_i   <= t;
    do @(posedge clk_i); while (stall_o);
    expected_normals.push_back(known ? n : predicted);
    if (fl) flipped_seen++;
    @(negedge clk_i);
  endtask

  // Random coordinate: mostly full range, sometimes small or at an extreme.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(9)) inside
      0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1, 2: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tri_t pick_triangle();
    tri_t t;
    t = tri_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    t.p0_x = pick_coord(); t.p0_y = pick_coord(); t.p0_z = pick_coord();
    t.p1_x = pick_coord(); t.p1_y = pick_coord(); t.p1_z = pick_coord();
    t.p2_x = pick_coord(); t.p2_y = pick_coord(); t.p2_z = pick_coord();
    case ($urandom_range(19))
      // Collinear: p2 returns to p0 along the first edge.
      0: begin t.p2_x = t.p0_x; t.p2_y = t.p0_y; t.p2_z = t.p0_z; end
      // Repeated vertex.
      1: begin t.p2_x = t.p1_x; t.p2_y = t.p1_y; t.p2_z = t.p1_z; end
      default: ;
    endcase
    return t;
  endfunction

  // Receiver stall, changed at the falling edge.
  always @(negedge clk_i) begin
    stall_i <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Checks each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected normal %p", norm_o);
      end else begin
        normal_t want;
        want = expected_normals.pop_front();
        normals_seen++;
        if (want.degenerate) degenerate_seen++;
        if (norm_o.normal_x !== want.normal_x || norm_o.normal_y !== want.normal_y ||
            norm_o.normal_z !== want.normal_z || norm_o.degenerate !== want.degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal mismatch: expected %p, got %p", want, norm_o);
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_triangle(directed_rows[i].t, directed_rows[i].known, directed_rows[i].n);
    valid_i <= 1'b0;

    // Sender pauses until every result has come back.
    while (expected_normals.size() != 0) @(negedge clk_i);

    for (int k = 0; k < RandomTris; k++) begin
      phase = (k / 150) % 4;
      send_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 20 : 0;
      recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 20 : 0;
      send_triangle(pick_triangle(), 1'b0, '0);
    end
    valid_i <= 1'b0;
    recv_stall_pct = 0;

    while (expected_normals.size() != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);

    $display("Covered %0d triangles: %0d degenerate, %0d normals negated outward,",
             normals_seen, degenerate_seen, flipped_seen);
    $display("with sender gaps and receiver stalls in several mixes.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
